@@ sv/gmds_pkg.sv @@
package gmds_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OPEN    = 2'd0;
    localparam logic [1:0] ST_WALL    = 2'd1;
    localparam logic [1:0] ST_VISITED = 2'd2;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_STEP  = 6'b000100,
        S_CHECK = 6'b001000,
        S_POP   = 6'b010000,
        S_OUT   = 6'b100000
    } fsm_t;

endpackage

@@ sv/gmds_ram.sv @@
module gmds_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/grid_maze_dfs_solver_unit.sv @@
// channel | dir | tuser          | tdata
// s_      | in  | [1:0] command  | [2:0] row, [5:3] col, [6] wall, [7] zero
// m_      | out | -              | [0] found, [2:1] cell_state, [7:3] zero
//
// Write, read and unused commands pass from S_IDLE to S_OUT, through S_FETCH for an
// in-grid read. A solve runs one step of the search FSM per cycle, save while S_OUT
// waits on m_tready: S_STEP and S_CHECK per in-grid neighbor probed (grid RAM read),
// S_STEP alone per off-grid direction and S_POP per backtrack (stack RAM read). A cell
// is top of stack once plus once per child. Reset clears the FSM, the stack depth and
// one valid flop per grid cell; a cell whose flop is clear reads as open. A new word is
// taken as soon as the FSM is idle, even while the previous result is still held on m_.
module grid_maze_dfs_solver_unit #(
    parameter int SIDE = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // row, col, wall
    input  logic [1:0] s_tuser,   // command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // found, cell_state
);

    import gmds_pkg::*;

    localparam int CELLS = SIDE * SIDE;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = $clog2(SIDE);
    localparam int DW    = $clog2(CELLS + 1);
    localparam logic [RW-1:0] LAST  = RW'(SIDE - 1);
    localparam logic [4:0]    SIDE5 = 5'(SIDE);

    fsm_t            state_reg, state_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic [RW-1:0]   top_row_reg, top_row_next, top_col_reg, top_col_next;
    logic [RW-1:0]   nb_row_reg, nb_row_next, nb_col_reg, nb_col_next;
    logic [1:0]      dir_reg, dir_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic            found_reg, found_next;
    logic [1:0]      cstate_reg, cstate_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            m_found_reg, m_found_next;
    logic [1:0]      m_cstate_reg, m_cstate_next;
    logic [CELLS-1:0] vld_reg;
    logic            gvld_reg;

    logic            g_we;
    logic [IW-1:0]   g_waddr, g_raddr;
    logic [1:0]      g_wdata, g_rdata, grid_state;
    logic            k_we;
    logic [IW-1:0]   k_waddr, k_raddr;
    logic [2*RW-1:0] k_wdata, k_rdata;

    logic [1:0]      in_cmd;
    logic [4:0]      in_row5, in_col5;
    logic            in_wall, in_grid;
    logic [RW-1:0]   in_row, in_col;
    logic [IW-1:0]   in_idx, top_idx, nb_idx, nbr_idx;
    logic            nb_ok, adv;
    logic [RW-1:0]   nr, nc;

    assign in_cmd  = s_tuser;
    assign in_row5 = {2'b00, s_tdata[2:0]};
    assign in_col5 = {2'b00, s_tdata[5:3]};
    assign in_wall = s_tdata[6];
    assign in_grid = (in_row5 < SIDE5) && (in_col5 < SIDE5);
    assign in_row  = in_row5[RW-1:0];
    assign in_col  = in_col5[RW-1:0];
    assign in_idx  = IW'(IW'(in_row) * IW'(SIDE)) + IW'(in_col);
    assign top_idx = IW'(IW'(top_row_reg) * IW'(SIDE)) + IW'(top_col_reg);
    assign nb_idx  = IW'(IW'(nb_row_reg) * IW'(SIDE)) + IW'(nb_col_reg);
    assign nbr_idx = IW'(IW'(nr) * IW'(SIDE)) + IW'(nc);

    assign grid_state = gvld_reg ? g_rdata : ST_OPEN;

    always_comb begin
        nr    = top_row_reg;
        nc    = top_col_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_LEFT: begin
                nb_ok = top_col_reg != '0;
                nc    = top_col_reg - RW'(1);
            end
            DIR_DOWN: begin
                nb_ok = top_row_reg != LAST;
                nr    = top_row_reg + RW'(1);
            end
            DIR_RIGHT: begin
                nb_ok = top_col_reg != LAST;
                nc    = top_col_reg + RW'(1);
            end
            DIR_UP: begin
                nb_ok = top_row_reg != '0;
                nr    = top_row_reg - RW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign s_tready = state_reg == S_IDLE;

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        top_row_next  = top_row_reg;
        top_col_next  = top_col_reg;
        nb_row_next   = nb_row_reg;
        nb_col_next   = nb_col_reg;
        dir_next      = dir_reg;
        depth_next    = depth_reg;
        found_next    = found_reg;
        cstate_next   = cstate_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_found_next  = m_found_reg;
        m_cstate_next = m_cstate_reg;
        g_we          = 1'b0;
        g_waddr       = in_idx;
        g_wdata       = ST_OPEN;
        g_raddr       = in_idx;
        k_we          = 1'b0;
        k_waddr       = depth_reg[IW-1:0];
        k_wdata       = {top_row_reg, top_col_reg};
        k_raddr       = IW'(depth_reg - DW'(2));
        adv           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = in_cmd;
                    top_row_next = in_row;
                    top_col_next = in_col;
                    found_next   = 1'b0;
                    case (in_cmd)
                        CMD_WRITE: begin
                            g_we        = in_grid;
                            g_wdata     = in_wall ? ST_WALL : ST_OPEN;
                            cstate_next = (in_grid && !in_wall) ? ST_OPEN : ST_WALL;
                            state_next  = S_OUT;
                        end
                        CMD_SOLVE, CMD_READ: begin
                            cstate_next = ST_WALL;
                            state_next  = in_grid ? S_FETCH : S_OUT;
                        end
                        default: begin
                            cstate_next = ST_OPEN;
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                if (cmd_reg == CMD_READ || grid_state == ST_WALL) begin
                    cstate_next = grid_state;
                    state_next  = S_OUT;
                end else begin
                    g_we        = 1'b1;
                    g_waddr     = top_idx;
                    g_wdata     = ST_VISITED;
                    k_we        = 1'b1;
                    k_waddr     = '0;
                    cstate_next = ST_VISITED;
                    dir_next    = DIR_LEFT;
                    if (top_row_reg == LAST) begin
                        found_next = 1'b1;
                        depth_next = '0;
                        state_next = S_OUT;
                    end else begin
                        depth_next = DW'(1);
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (nb_ok) begin
                    g_raddr     = nbr_idx;
                    nb_row_next = nr;
                    nb_col_next = nc;
                    state_next  = S_CHECK;
                end else begin
                    adv = 1'b1;
                end
            end
            S_CHECK: begin
                if (grid_state == ST_OPEN) begin
                    g_we         = 1'b1;
                    g_waddr      = nb_idx;
                    g_wdata      = ST_VISITED;
                    k_we         = 1'b1;
                    k_wdata      = {nb_row_reg, nb_col_reg};
                    top_row_next = nb_row_reg;
                    top_col_next = nb_col_reg;
                    dir_next     = DIR_LEFT;
                    if (nb_row_reg == LAST) begin
                        found_next = 1'b1;
                        depth_next = '0;
                        state_next = S_OUT;
                    end else begin
                        depth_next = depth_reg + DW'(1);
                        state_next = S_STEP;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            S_POP: begin
                top_row_next = k_rdata[2*RW-1:RW];
                top_col_next = k_rdata[RW-1:0];
                dir_next     = DIR_LEFT;
                state_next   = S_STEP;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = found_reg;
                    m_cstate_next = cstate_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // next direction, or backtrack (or end the search at the start cell) once all four are spent
        if (adv) begin
            if (dir_reg != DIR_UP) begin
                dir_next   = dir_reg + 2'd1;
                state_next = S_STEP;
            end else if (depth_reg == DW'(1)) begin
                depth_next = '0;
                state_next = S_OUT;
            end else begin
                depth_next = depth_reg - DW'(1);
                state_next = S_POP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            vld_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            m_tvalid_reg <= m_tvalid_next;
            if (g_we) begin
                vld_reg[g_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        top_row_reg  <= top_row_next;
        top_col_reg  <= top_col_next;
        nb_row_reg   <= nb_row_next;
        nb_col_reg   <= nb_col_next;
        dir_reg      <= dir_next;
        found_reg    <= found_next;
        cstate_reg   <= cstate_next;
        m_found_reg  <= m_found_next;
        m_cstate_reg <= m_cstate_next;
        gvld_reg     <= vld_reg[g_raddr];
    end

    gmds_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_grid (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gmds_ram #(
        .WIDTH (2 * RW),
        .DEPTH (CELLS)
    ) u_stack (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, m_cstate_reg, m_found_reg};

endmodule
